FILE: sv/date_add_days_compare_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the date adder core
// Clocked property checks, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_COMPARE_CORE_DEFINES_SVH
`define DATE_ADD_DAYS_COMPARE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define DADC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define DADC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DADC_ASSERT(lbl, prop, msg)
`define DADC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/dadc_pkg.sv
// ---------------------------------------------------------------------------
// dadc_pkg
// Shared types, constants and calendar helpers of the date adder core.
// ---------------------------------------------------------------------------
`default_nettype none

package dadc_pkg;

  localparam int unsigned ADD_DAYS_MAX_DEF = 4095;
  localparam int unsigned DAYS_IN_MAX      = 4095;   // largest days_to_add value

  localparam logic [14:0] YEAR_LIMIT  = 15'd9999;
  localparam logic [13:0] LEAP_CYCLE  = 14'd400;
  localparam logic [13:0] CENTURY     = 14'd100;
  localparam int unsigned REDUCE_STEPS = 6;          // 400<<5 .. 400<<0

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load;       // capture input word
    logic       reduce;     // one restoring step of year mod 400
    logic [2:0] red_idx;    // shift of 400 for that step
    logic       walk;       // advance one month
    logic       load_out;   // move result into output register
  } cmd_t;

  typedef struct packed {
    logic walk_done;        // day fits in current month
    logic bad;              // start month out of range
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      len = 5'd30;
    end else if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dadc_ctrl.sv
// ---------------------------------------------------------------------------
// dadc_ctrl
// Sequencer: capture, year reduction, month walk, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "date_add_days_compare_core_defines.svh"

module dadc_ctrl
  import dadc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = 3'(REDUCE_STEPS - 1);
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.reduce  = 1'b1;
        cmd_o.red_idx = cnt_q;
        if (cnt_q == '0) begin
          state_d = status_i.bad ? ST_FINISH : ST_WALK;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `DADC_ASSERT(a_one_word_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o, "second word taken while busy")
  `DADC_ASSERT(a_no_walk_on_bad, (state_q == ST_WALK) |-> !status_i.bad, "month walk started on bad month")
  `DADC_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "pending result overwritten")
  `DADC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

`default_nettype wire

FILE: sv/dadc_dp.sv
// ---------------------------------------------------------------------------
// dadc_dp
// Datapath: comparison flags, year mod 400 reduction, month walk, output regs.
// ---------------------------------------------------------------------------
`default_nettype none
`include "date_add_days_compare_core_defines.svh"

module dadc_dp
  import dadc_pkg::*;
#(
  parameter int unsigned ADD_DAYS_MAX = ADD_DAYS_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic [4:0]  day_a_i,
  input  wire logic [3:0]  month_a_i,
  input  wire logic [13:0] year_a_i,
  input  wire logic [4:0]  day_b_i,
  input  wire logic [3:0]  month_b_i,
  input  wire logic [13:0] year_b_i,
  input  wire logic [11:0] days_to_add_i,
  output logic [4:0]       sum_day_o,
  output logic [3:0]       sum_month_o,
  output logic [13:0]      sum_year_o,
  output logic             a_greater_o,
  output logic             a_less_o,
  output logic             a_equal_o,
  output logic             bad_input_o,
  output logic             year_overflow_o
);

  localparam int unsigned NMAX  = (ADD_DAYS_MAX < DAYS_IN_MAX) ? ADD_DAYS_MAX : DAYS_IN_MAX;
  localparam int unsigned DAY_W = $clog2(NMAX + 32);
  localparam logic [11:0] NMAX_W = 12'(NMAX);

  logic [DAY_W-1:0] d_q;
  logic [3:0]       m_q;
  logic [14:0]      y_q;
  logic [13:0]      r_q;        // year mod 400 once reduced
  logic             gt_q, lt_q, eq_q, bad_q;

  logic [11:0]      n_sat;
  logic             gt, eq;
  logic             leap;
  logic [4:0]       len;
  logic [13:0]      red_sub;
  logic             ovf;

  assign n_sat = (days_to_add_i > NMAX_W) ? NMAX_W : days_to_add_i;

  always_comb begin
    if (year_a_i != year_b_i) begin
      gt = year_a_i > year_b_i;
    end else if (month_a_i != month_b_i) begin
      gt = month_a_i > month_b_i;
    end else begin
      gt = day_a_i > day_b_i;
    end
  end
  assign eq = (year_a_i == year_b_i) && (month_a_i == month_b_i) && (day_a_i == day_b_i);

  // y mod 4 equals r mod 4; centuries sit at 100, 200 and 300 within the cycle
  assign leap = (r_q[1:0] == 2'b00) && (r_q != CENTURY) && (r_q != 14'(2 * CENTURY))
                && (r_q != 14'(3 * CENTURY));
  assign len  = month_len(m_q, leap);
  assign red_sub = LEAP_CYCLE << cmd_i.red_idx;

  assign status_o.walk_done = d_q <= DAY_W'(len);
  assign status_o.bad       = bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q   <= DAY_W'(day_a_i) + DAY_W'(n_sat);
      m_q   <= month_a_i;
      y_q   <= {1'b0, year_a_i};
      r_q   <= year_a_i;
      gt_q  <= gt;
      eq_q  <= eq;
      lt_q  <= !gt && !eq;
      bad_q <= (month_a_i < MONTH_JAN) || (month_a_i > MONTH_DEC);
    end else if (cmd_i.reduce) begin
      if (r_q >= red_sub) begin
        r_q <= r_q - red_sub;
      end
    end else if (cmd_i.walk) begin
      d_q <= d_q - DAY_W'(len);
      if (m_q == MONTH_DEC) begin
        m_q <= MONTH_JAN;
        y_q <= y_q + 15'd1;
        r_q <= (r_q == LEAP_CYCLE - 14'd1) ? '0 : r_q + 14'd1;
      end else begin
        m_q <= m_q + 4'd1;
      end
    end
  end

  assign ovf = y_q > YEAR_LIMIT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sum_day_o       <= bad_q ? '0 : d_q[4:0];
      sum_month_o     <= bad_q ? '0 : m_q;
      sum_year_o      <= bad_q ? '0 : (ovf ? YEAR_LIMIT[13:0] : y_q[13:0]);
      year_overflow_o <= !bad_q && ovf;
      bad_input_o     <= bad_q;
      a_greater_o     <= gt_q;
      a_less_o        <= lt_q;
      a_equal_o       <= eq_q;
    end
  end

  `DADC_ASSERT(a_walk_month_range, cmd_i.walk |-> (m_q >= MONTH_JAN && m_q <= MONTH_DEC), "month out of range in walk")
  `DADC_ASSERT(a_walk_reduced, cmd_i.walk |-> (r_q < LEAP_CYCLE), "year not reduced before walk")

endmodule

`default_nettype wire

FILE: sv/date_add_days_compare_core.sv
// Sequence: capture the input word, reduce the year mod 400 by restoring steps,
//   walk the days month by month (skipped for a bad start month), then move the
//   result into the output register once any earlier result has been taken.
// Only one word is in flight; once its result is loaded, a new word is taken
//   while that result still waits.
// Reset (async, active low) clears the sequencer and output valid only.
`default_nettype none

module date_add_days_compare_core
  import dadc_pkg::*;
#(
  parameter int unsigned ADD_DAYS_MAX = ADD_DAYS_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  day_a_i,
  input  wire logic [3:0]  month_a_i,
  input  wire logic [13:0] year_a_i,
  input  wire logic [4:0]  day_b_i,
  input  wire logic [3:0]  month_b_i,
  input  wire logic [13:0] year_b_i,
  input  wire logic [11:0] days_to_add_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       sum_day_o,
  output logic [3:0]       sum_month_o,
  output logic [13:0]      sum_year_o,
  output logic             a_greater_o,
  output logic             a_less_o,
  output logic             a_equal_o,
  output logic             bad_input_o,
  output logic             year_overflow_o
);

  cmd_t    cmd;
  status_t status;

  dadc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dadc_dp #(
    .ADD_DAYS_MAX (ADD_DAYS_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .day_a_i         (day_a_i),
    .month_a_i       (month_a_i),
    .year_a_i        (year_a_i),
    .day_b_i         (day_b_i),
    .month_b_i       (month_b_i),
    .year_b_i        (year_b_i),
    .days_to_add_i   (days_to_add_i),
    .sum_day_o       (sum_day_o),
    .sum_month_o     (sum_month_o),
    .sum_year_o      (sum_year_o),
    .a_greater_o     (a_greater_o),
    .a_less_o        (a_less_o),
    .a_equal_o       (a_equal_o),
    .bad_input_o     (bad_input_o),
    .year_overflow_o (year_overflow_o)
  );

endmodule

`default_nettype wire
